>>> rtl/srr_pkg.sv
// Shared constants, types and helper functions for the selective repeat receiver.
package srr_pkg;

  localparam int WINDOW_SIZE = 6;
  localparam int SEQ_SPACE = 12;
  localparam int NWORDS = 5;
  localparam int WORD_W = 32;
  localparam int ROW_W = NWORDS * WORD_W;
  localparam int ZERO_BYTES_SUM = 960;

  localparam int SEQ_W = $clog2(SEQ_SPACE);
  localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int WIN_LAST = (WINDOW_SIZE - 1) % SEQ_SPACE;

  localparam int IN_SEQ_W = 21;
  localparam int CHK_W = 32;
  localparam int ACK_NUM_W = 4;
  localparam int ACK_CHK_W = 10;
  localparam int WSUM_W = 10;
  localparam int TOTAL_W = 23;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK = 1'b1;

  typedef struct packed {
    logic load_in;
    logic sum;
    logic classify;
    logic read;
    logic emit_data;
    logic emit_ack;
  } srr_cmd_t;

  typedef struct packed {
    logic store_new;
    logic at_base;
    logic base_filled;
    logic out_free;
  } srr_status_t;

  // Slot of a sequence number inside the receive window buffer.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_W-1:0] s);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = 0; i < SEQ_SPACE; i++) begin
      if (s == SEQ_W'(i)) begin
        r = SLOT_W'(i % WINDOW_SIZE);
      end
    end
    return r;
  endfunction

  // Sum of the four bytes of a word, each byte read as a signed value.
  function automatic logic signed [WSUM_W-1:0] word_byte_sum(input logic [WORD_W-1:0] w);
    logic signed [WSUM_W-1:0] s;
    s = '0;
    for (int k = 0; k < 4; k++) begin
      s = s + WSUM_W'($signed(w[8*k +: 8]));
    end
    return s;
  endfunction

endpackage

>>> rtl/srr_ctrl.sv
// Controller state machine that sequences checking, buffering, delivery and ACK.
module srr_ctrl
  import srr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  srr_status_t status,
  output srr_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_CLASSIFY,
    S_PROBE,
    S_EMIT_D,
    S_ACK
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_nxt = S_CLASSIFY;
      end
      S_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_nxt = (status.store_new && status.at_base) ? S_PROBE : S_ACK;
      end
      S_PROBE: begin
        if (status.base_filled) begin
          cmd.read = 1'b1;
          state_nxt = S_EMIT_D;
        end else begin
          state_nxt = S_ACK;
        end
      end
      S_EMIT_D: begin
        if (status.out_free) begin
          cmd.emit_data = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_ACK: begin
        if (status.out_free) begin
          cmd.emit_ack = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/srr_datapath.sv
// Datapath with checksum, window state, payload buffer and output register.
module srr_datapath
  import srr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  srr_cmd_t                     cmd,
  output srr_status_t                  status,
  input  logic signed [IN_SEQ_W-1:0]   in_seq_number,
  input  logic signed [IN_SEQ_W-1:0]   in_ack_field,
  input  logic signed [CHK_W-1:0]      in_packet_checksum,
  input  logic [WORD_W-1:0]            in_payload_word0,
  input  logic [WORD_W-1:0]            in_payload_word1,
  input  logic [WORD_W-1:0]            in_payload_word2,
  input  logic [WORD_W-1:0]            in_payload_word3,
  input  logic [WORD_W-1:0]            in_payload_word4,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_result_kind,
  output logic [WORD_W-1:0]            out_deliver_word0,
  output logic [WORD_W-1:0]            out_deliver_word1,
  output logic [WORD_W-1:0]            out_deliver_word2,
  output logic [WORD_W-1:0]            out_deliver_word3,
  output logic [WORD_W-1:0]            out_deliver_word4,
  output logic [ACK_NUM_W-1:0]         out_ack_number,
  output logic                         out_ack_seq_bit,
  output logic [ACK_CHK_W-1:0]         out_ack_checksum,
  output logic                         out_last_result
);

  logic signed [IN_SEQ_W-1:0] seq_r;
  logic signed [IN_SEQ_W-1:0] ackf_r;
  logic signed [CHK_W-1:0]    chk_r;
  logic [ROW_W-1:0]           row_in_r;
  logic signed [WSUM_W-1:0]   wsum_r [NWORDS];

  logic [ROW_W-1:0]           store_mem [WINDOW_SIZE];
  logic [ROW_W-1:0]           rd_row_r;
  logic [WINDOW_SIZE-1:0]     filled_r;
  logic [SEQ_W-1:0]           base_r;
  logic [SEQ_W-1:0]           last_ack_r;
  logic                       last_ack_valid_r;
  logic                       toggle_r;
  logic [SEQ_W-1:0]           ack_num_r;

  logic                       out_valid_r;
  logic                       kind_r;
  logic [ROW_W-1:0]           out_row_r;
  logic [ACK_NUM_W-1:0]       out_ack_r;
  logic                       out_bit_r;
  logic [ACK_CHK_W-1:0]       out_chk_r;
  logic                       out_last_r;

  logic signed [TOTAL_W-1:0]  total;
  logic                       sum_ok;
  logic                       seq_in_range;
  logic [SEQ_W-1:0]           seq4;
  logic [SEQ_W:0]             offset;
  logic                       in_win;
  logic [SEQ_W-1:0]           base_minus1;
  logic                       below;
  logic [SEQ_W-1:0]           repeat_ack;
  logic [SLOT_W-1:0]          seq_slot;
  logic [SLOT_W-1:0]          base_slot;
  logic                       out_free;

  always_comb begin
    total = TOTAL_W'(seq_r) + TOTAL_W'(ackf_r);
    for (int j = 0; j < NWORDS; j++) begin
      total = total + TOTAL_W'(wsum_r[j]);
    end
  end

  assign sum_ok = (CHK_W'(total) == chk_r);
  assign seq_in_range = (seq_r >= 0) && (seq_r < IN_SEQ_W'(SEQ_SPACE));
  assign seq4 = seq_r[SEQ_W-1:0];
  assign offset = (seq4 >= base_r) ? ({1'b0, seq4} - {1'b0, base_r})
                                   : ({1'b0, seq4} + (SEQ_W+1)'(SEQ_SPACE) - {1'b0, base_r});
  assign in_win = seq_in_range && (offset != (SEQ_W+1)'(SEQ_SPACE - 1))
                  && (offset <= (SEQ_W+1)'(WIN_LAST));
  assign base_minus1 = (base_r == '0) ? SEQ_W'(SEQ_SPACE - 1) : base_r - SEQ_W'(1);
  assign below = seq_in_range && (seq4 == base_minus1);
  assign repeat_ack = last_ack_valid_r ? last_ack_r : base_minus1;
  assign seq_slot = slot_of(seq4);
  assign base_slot = slot_of(base_r);
  assign out_free = !out_valid_r || !out_stall;

  assign status.store_new = sum_ok && in_win && !filled_r[seq_slot];
  assign status.at_base = (seq4 == base_r);
  assign status.base_filled = filled_r[base_slot];
  assign status.out_free = out_free;

  // Input capture and checksum partial sums.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      seq_r <= in_seq_number;
      ackf_r <= in_ack_field;
      chk_r <= in_packet_checksum;
      row_in_r <= {in_payload_word4, in_payload_word3, in_payload_word2,
                   in_payload_word1, in_payload_word0};
    end
    if (cmd.sum) begin
      for (int j = 0; j < NWORDS; j++) begin
        wsum_r[j] <= word_byte_sum(row_in_r[j*WORD_W +: WORD_W]);
      end
    end
  end

  // Payload buffer, one row per window slot.
  always_ff @(posedge clk) begin
    if (cmd.classify && status.store_new) begin
      store_mem[seq_slot] <= row_in_r;
    end
    if (cmd.read) begin
      rd_row_r <= store_mem[base_slot];
    end
  end

  // Window state and the acknowledged number.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      base_r <= '0;
      last_ack_r <= '0;
      last_ack_valid_r <= 1'b0;
      toggle_r <= 1'b1;
    end else begin
      if (cmd.classify) begin
        if (sum_ok && (in_win || below)) begin
          last_ack_r <= seq4;
          last_ack_valid_r <= 1'b1;
        end
        if (status.store_new) begin
          filled_r[seq_slot] <= 1'b1;
        end
      end
      if (cmd.read) begin
        filled_r[base_slot] <= 1'b0;
        base_r <= (base_r == SEQ_W'(SEQ_SPACE - 1)) ? '0 : base_r + SEQ_W'(1);
      end
      if (cmd.emit_ack) begin
        toggle_r <= !toggle_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      ack_num_r <= (sum_ok && (in_win || below)) ? seq4 : repeat_ack;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_data || cmd.emit_ack) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_data) begin
      kind_r <= KIND_DELIVER;
      out_row_r <= rd_row_r;
      out_ack_r <= '0;
      out_bit_r <= 1'b0;
      out_chk_r <= '0;
      out_last_r <= 1'b0;
    end else if (cmd.emit_ack) begin
      kind_r <= KIND_ACK;
      out_row_r <= '0;
      out_ack_r <= ACK_NUM_W'(ack_num_r);
      out_bit_r <= toggle_r;
      out_chk_r <= ACK_CHK_W'(toggle_r) + ACK_CHK_W'(ack_num_r) + ACK_CHK_W'(ZERO_BYTES_SUM);
      out_last_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_deliver_word0 = out_row_r[0*WORD_W +: WORD_W];
  assign out_deliver_word1 = out_row_r[1*WORD_W +: WORD_W];
  assign out_deliver_word2 = out_row_r[2*WORD_W +: WORD_W];
  assign out_deliver_word3 = out_row_r[3*WORD_W +: WORD_W];
  assign out_deliver_word4 = out_row_r[4*WORD_W +: WORD_W];
  assign out_ack_number = out_ack_r;
  assign out_ack_seq_bit = out_bit_r;
  assign out_ack_checksum = out_chk_r;
  assign out_last_result = out_last_r;

endmodule

>>> rtl/selective_repeat_receiver.sv
// Top level of the selective repeat receiver: controller plus datapath.
//
//   Channel   Direction  Handshake          Word
//   in_       input      in_valid/in_stall  one data packet
//   out_      output     out_valid/out_stall one delivery or the closing ACK
//
// A packet is accepted only while the controller is idle and then passes the sum,
// classify and ACK steps; a new packet at the base adds probe and delivery steps.
// Each result waits in the output register until the receiver takes it.
// A full output register under stall holds the delivery and ACK steps.
// Reset clears the window state and the output valid; the buffer is not cleared.
module selective_repeat_receiver
  import srr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [IN_SEQ_W-1:0]   in_seq_number,
  input  logic signed [IN_SEQ_W-1:0]   in_ack_field,
  input  logic signed [CHK_W-1:0]      in_packet_checksum,
  input  logic [WORD_W-1:0]            in_payload_word0,
  input  logic [WORD_W-1:0]            in_payload_word1,
  input  logic [WORD_W-1:0]            in_payload_word2,
  input  logic [WORD_W-1:0]            in_payload_word3,
  input  logic [WORD_W-1:0]            in_payload_word4,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_result_kind,
  output logic [WORD_W-1:0]            out_deliver_word0,
  output logic [WORD_W-1:0]            out_deliver_word1,
  output logic [WORD_W-1:0]            out_deliver_word2,
  output logic [WORD_W-1:0]            out_deliver_word3,
  output logic [WORD_W-1:0]            out_deliver_word4,
  output logic [ACK_NUM_W-1:0]         out_ack_number,
  output logic                         out_ack_seq_bit,
  output logic [ACK_CHK_W-1:0]         out_ack_checksum,
  output logic                         out_last_result
);

  srr_cmd_t    cmd;
  srr_status_t status;

  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  srr_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_seq_number      (in_seq_number),
    .in_ack_field       (in_ack_field),
    .in_packet_checksum (in_packet_checksum),
    .in_payload_word0   (in_payload_word0),
    .in_payload_word1   (in_payload_word1),
    .in_payload_word2   (in_payload_word2),
    .in_payload_word3   (in_payload_word3),
    .in_payload_word4   (in_payload_word4),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_deliver_word0  (out_deliver_word0),
    .out_deliver_word1  (out_deliver_word1),
    .out_deliver_word2  (out_deliver_word2),
    .out_deliver_word3  (out_deliver_word3),
    .out_deliver_word4  (out_deliver_word4),
    .out_ack_number     (out_ack_number),
    .out_ack_seq_bit    (out_ack_seq_bit),
    .out_ack_checksum   (out_ack_checksum),
    .out_last_result    (out_last_result)
  );

endmodule
